@@ hw/rtl/pf929_pkg.sv @@
`default_nettype none

package pf929_pkg;

    localparam int MODULUS_DEF   = 929;
    localparam int GENERATOR_DEF = 3;

    localparam int ACT_W = 3;
    localparam int IN_W  = 10;
    localparam int VAL_W = 10;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam int PIPE_STAGES = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_INV = 3'd3,
        ACT_EXP = 3'd4,
        ACT_LOG = 3'd5
    } action_t;

endpackage

`default_nettype wire

@@ hw/rtl/pf929_ram.sv @@
`default_nettype none

module pf929_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 929
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/prime_field_929_arith_unit_top.sv @@
// Channel  Dir  Handshake                 Payload (lowest bit up)
// s_axis   in   s_axis_tvalid/tready      tdata: action[2:0], a[12:3], b[22:13], zero[23]
// m_axis   out  m_axis_tvalid/tready      tdata: value[9:0], zero[15:10]; tuser: error
//
// One transaction per cycle while m_axis_tready does not stall the pipe; registered
// stages from accept to m_axis_tvalid: two stages of constant reduction, log table
// read, address/add stage, power table read. After reset the tables are built by a
// sweep over the entries, each step a modular multiply of the generator power through
// prod_reg, qx_reg and qm_reg; s_axis_tready stays low until the sweep is done.
// Each stage holds while the next is full and held; empty stages fill under a stall.
`default_nettype none

module prime_field_929_arith_unit_top
    import pf929_pkg::*;
#(
    parameter int MODULUS   = MODULUS_DEF,
    parameter int GENERATOR = GENERATOR_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // action, a, b
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata,   // value
    output      logic                   m_axis_tuser    // error
);

    localparam int EW = $clog2(MODULUS);
    localparam int DW = 2 * EW;
    localparam int CW = ((EW > IN_W) ? EW : IN_W) + 1;

    localparam logic [EW-1:0] MOD_E     = EW'(MODULUS);
    localparam logic [EW:0]   MOD_W     = (EW + 1)'(MODULUS);
    localparam logic [EW:0]   ORD_W     = (EW + 1)'(MODULUS - 1);
    localparam logic [EW-1:0] ORD_E     = EW'(MODULUS - 1);
    localparam logic [CW-1:0] MOD_C     = CW'(MODULUS);
    localparam logic [CW-1:0] ORD_C     = CW'(MODULUS - 1);
    localparam logic [DW-1:0] MOD_D     = DW'(MODULUS);
    localparam logic [EW-1:0] GEN_E     = EW'(GENERATOR % MODULUS);
    localparam logic [DW-1:0] RCP_X     = DW'((2 ** DW) / MODULUS);
    localparam logic [IN_W-1:0] RCP_A   = IN_W'((2 ** IN_W) / MODULUS);
    localparam logic [IN_W-1:0] RCP_O   = IN_W'((2 ** IN_W) / (MODULUS - 1));
    localparam logic [EW-1:0] LAST_CLR  = EW'(MODULUS - 1);
    localparam logic [EW-1:0] LAST_FILL = EW'(MODULUS - 2);
    localparam logic [EW-1:0] ONE_E     = EW'(1);
    localparam logic [1:0]    SUB_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_CLR  = 3'b001,
        ST_FILL = 3'b010,
        ST_RUN  = 3'b100
    } init_state_t;

    // estimated quotient x / m from the reciprocal, low by at most one
    function automatic logic [IN_W-1:0] quo(input logic [IN_W-1:0] x,
                                            input logic [IN_W-1:0] rcp);
        logic [2*IN_W-1:0] p;
        p   = (2 * IN_W)'(x) * (2 * IN_W)'(rcp);
        quo = p[2*IN_W-1:IN_W];
    endfunction

    function automatic logic [EW-1:0] fold(input logic [IN_W-1:0] x,
                                           input logic [IN_W-1:0] q,
                                           input logic [CW-1:0]   m);
        logic [CW+IN_W-1:0] qm;
        logic [CW-1:0]      r;
        qm   = (CW + IN_W)'(q) * (CW + IN_W)'(m);
        r    = CW'(x) - CW'(qm);
        fold = (r >= m) ? EW'(r - m) : EW'(r);
    endfunction

    // table build sequencer
    init_state_t   st_reg, st_next;
    logic [1:0]    sub_reg;
    logic [EW-1:0] idx_reg, idx_next;
    logic [EW-1:0] x_reg, x_next;
    logic [DW-1:0] prod_reg;
    logic [EW-1:0] qx_reg;
    logic [DW-1:0] qm_reg;
    logic [2*DW-1:0] pq;
    logic [DW-1:0] rx;
    logic [EW-1:0] x_step;
    logic          step_done;

    logic          pwr_we;
    logic          log_we;
    logic [EW-1:0] log_waddr;
    logic [EW-1:0] log_wdata;

    assign step_done = (sub_reg == SUB_LAST) && (st_reg != ST_RUN);
    assign pq        = (2 * DW)'(prod_reg) * (2 * DW)'(RCP_X);
    assign rx        = prod_reg - qm_reg;
    assign x_step    = (rx >= MOD_D) ? EW'(rx - MOD_D) : EW'(rx);

    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        x_next   = x_reg;
        if (step_done)
        begin
            idx_next = idx_reg + ONE_E;
            x_next   = x_step;
            case (st_reg)
                ST_CLR:
                begin
                    if (idx_reg == LAST_CLR)
                    begin
                        st_next  = ST_FILL;
                        idx_next = '0;
                        x_next   = ONE_E;
                    end
                end
                ST_FILL:
                begin
                    if (idx_reg == LAST_FILL)
                    begin
                        st_next = ST_RUN;
                    end
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_CLR;
            sub_reg <= '0;
            idx_reg <= '0;
            x_reg   <= ONE_E;
        end
        else
        begin
            st_reg  <= st_next;
            sub_reg <= (st_reg == ST_RUN) ? 2'd0 : sub_reg + 2'd1;
            idx_reg <= idx_next;
            x_reg   <= x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= DW'(x_reg) * DW'(GEN_E);
        qx_reg   <= EW'(pq[2*DW-1:DW]);
        qm_reg   <= DW'(qx_reg) * DW'(MOD_E);
    end

    assign pwr_we    = step_done && (st_reg == ST_CLR);
    assign log_we    = step_done;
    assign log_waddr = (st_reg == ST_CLR) ? idx_reg : x_reg;
    assign log_wdata = (st_reg == ST_CLR) ? '0 : idx_reg;

    // pipeline
    logic en1, en2, en3, en4, en5;

    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    action_t         act1_reg, act2_reg, act3_reg;
    logic [IN_W-1:0] a1_reg, b1_reg, qa1_reg, qb1_reg, qe1_reg;
    logic [EW-1:0]   ea2_reg, eb2_reg, ee2_reg;
    logic [EW-1:0]   ea3_reg, eb3_reg, ee3_reg;
    logic [EW-1:0]   la3, lb3;
    logic            pwr4_reg, err4_reg;
    logic [EW-1:0]   dv4_reg, pa4_reg;
    logic            pwr5_reg, err5_reg;
    logic [EW-1:0]   dv5_reg;
    logic [EW-1:0]   pd5;

    logic            in_act_ok;
    logic [IN_W-1:0] in_a, in_b;

    logic            pwr4_next, err4_next;
    logic [EW-1:0]   dv4_next, pa4_next;
    logic [EW:0]     sum_e, dif_e, lsum;
    logic [EW-1:0]   sum_m, dif_m, lsum_m;

    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1 && (st_reg == ST_RUN);
    assign in_act_ok     = s_axis_tvalid && s_axis_tready;
    assign in_a          = s_axis_tdata[ACT_W+IN_W-1:ACT_W];
    assign in_b          = s_axis_tdata[ACT_W+2*IN_W-1:ACT_W+IN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_act_ok;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            act1_reg <= action_t'(s_axis_tdata[ACT_W-1:0]);
            a1_reg   <= in_a;
            b1_reg   <= in_b;
            qa1_reg  <= quo(in_a, RCP_A);
            qb1_reg  <= quo(in_b, RCP_A);
            qe1_reg  <= quo(in_a, RCP_O);
        end
        if (en2)
        begin
            act2_reg <= act1_reg;
            ea2_reg  <= fold(a1_reg, qa1_reg, MOD_C);
            eb2_reg  <= fold(b1_reg, qb1_reg, MOD_C);
            ee2_reg  <= fold(a1_reg, qe1_reg, ORD_C);
        end
        if (en3)
        begin
            act3_reg <= act2_reg;
            ea3_reg  <= ea2_reg;
            eb3_reg  <= eb2_reg;
            ee3_reg  <= ee2_reg;
        end
        if (en4)
        begin
            pwr4_reg <= pwr4_next;
            err4_reg <= err4_next;
            dv4_reg  <= dv4_next;
            pa4_reg  <= pa4_next;
        end
        if (en5)
        begin
            pwr5_reg <= pwr4_reg;
            err5_reg <= err4_reg;
            dv5_reg  <= dv4_reg;
        end
    end

    assign sum_e  = {1'b0, ea3_reg} + {1'b0, eb3_reg};
    assign sum_m  = (sum_e >= MOD_W) ? EW'(sum_e - MOD_W) : EW'(sum_e);
    assign dif_e  = {1'b0, ea3_reg} + MOD_W - {1'b0, eb3_reg};
    assign dif_m  = (dif_e >= MOD_W) ? EW'(dif_e - MOD_W) : EW'(dif_e);
    assign lsum   = {1'b0, la3} + {1'b0, lb3};
    assign lsum_m = (lsum >= ORD_W) ? EW'(lsum - ORD_W) : EW'(lsum);

    always_comb
    begin
        pwr4_next = 1'b0;
        err4_next = 1'b0;
        dv4_next  = '0;
        pa4_next  = '0;
        case (act3_reg)
            ACT_ADD:
            begin
                dv4_next = sum_m;
            end
            ACT_SUB:
            begin
                dv4_next = dif_m;
            end
            ACT_MUL:
            begin
                if ((ea3_reg != '0) && (eb3_reg != '0))
                begin
                    pwr4_next = 1'b1;
                    pa4_next  = lsum_m;
                end
            end
            ACT_INV:
            begin
                if (ea3_reg == '0)
                begin
                    err4_next = 1'b1;
                end
                else
                begin
                    pwr4_next = 1'b1;
                    pa4_next  = ORD_E - la3;
                end
            end
            ACT_EXP:
            begin
                pwr4_next = 1'b1;
                pa4_next  = ee3_reg;
            end
            ACT_LOG:
            begin
                if (ea3_reg == '0)
                begin
                    err4_next = 1'b1;
                end
                else
                begin
                    dv4_next = la3;
                end
            end
            default:
            begin
                dv4_next = '0;
            end
        endcase
    end

    pf929_ram #(
        .WIDTH (EW),
        .DEPTH (MODULUS)
    ) u_log_ram_a (
        .clk     (clk),
        .wr_en   (log_we),
        .wr_addr (log_waddr),
        .wr_data (log_wdata),
        .rd_en   (en3),
        .rd_addr (ea2_reg),
        .rd_data (la3)
    );

    pf929_ram #(
        .WIDTH (EW),
        .DEPTH (MODULUS)
    ) u_log_ram_b (
        .clk     (clk),
        .wr_en   (log_we),
        .wr_addr (log_waddr),
        .wr_data (log_wdata),
        .rd_en   (en3),
        .rd_addr (eb2_reg),
        .rd_data (lb3)
    );

    pf929_ram #(
        .WIDTH (EW),
        .DEPTH (MODULUS)
    ) u_pwr_ram (
        .clk     (clk),
        .wr_en   (pwr_we),
        .wr_addr (idx_reg),
        .wr_data (x_reg),
        .rd_en   (en5),
        .rd_addr (pa4_reg),
        .rd_data (pd5)
    );

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(VAL_W'(pwr5_reg ? pd5 : dv5_reg));
    assign m_axis_tuser  = err5_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pf929_checker.sv @@
`default_nettype none

module pf929_checker
    import pf929_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    localparam int NW = $clog2(PIPE_STAGES + 1) + 1;

    logic [NW-1:0] cnt_reg, cnt_next;
    logic          in_xfer, out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_xfer && !out_xfer)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (!in_xfer && out_xfer)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result with nonzero value");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cnt_reg != '0)
        else $error("result without an accepted transaction");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(PIPE_STAGES))
        else $error("more transactions in flight than stages");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (MODULUS > 1024) || (int'(m_axis_tdata[VAL_W-1:0]) < MODULUS))
        else $error("value outside the field");

endmodule

bind prime_field_929_arith_unit_top pf929_checker #(
    .MODULUS (MODULUS)
) u_pf929_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
